// ===== src/ipv6_text_address_parser_assert.svh =====
// Assertion macros shared by the IPv6 text address parser modules.
// Depends on a clock named clk and an active-low reset named arst_n in the including module.
`ifndef IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define IPV6TAP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define IPV6TAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ipv6tap_pkg.sv =====
// Shared types, character codes and decode helpers for the IPv6 text address parser.
// No dependencies; used by ipv6tap_step, ipv6tap_finish and the top level.
package ipv6tap_pkg;

	localparam logic [7:0] CH_TERM  = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam int unsigned OCTET_MAX = 255;
	localparam int unsigned IN_W      = 8;
	localparam int unsigned OUT_W     = 136;

	typedef logic [15:0] group_t;
	// Slot 0 sits in the top bits, so a flattened array is the address itself.
	typedef logic [0:7][15:0] group_arr_t;

	typedef struct packed {
		logic       vld;
		logic       alpha;
		logic [3:0] val;
	} hex_info_t;

	// Parser state handed over when the terminator is taken.
	typedef struct packed {
		logic        failed;
		logic        lead_colon;
		logic        must_not_end;
		logic        dotted;
		logic        octet_nz;
		logic [1:0]  octet_cnt;
		logic [7:0]  octet;
		logic [23:0] quad;
		logic        digit_nz;
		group_t      hex_word;
		logic [3:0]  group_cnt;
		logic        gap_seen;
		logic [2:0]  gap_idx;
		group_arr_t  head;
		group_arr_t  tail;
	} snap_t;

	function automatic hex_info_t hex_decode(input logic [7:0] c);
		hex_info_t r;
		r = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r.vld = 1'b1;
			r.val = c[3:0];
		end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
			r.vld   = 1'b1;
			r.alpha = 1'b1;
			r.val   = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

// ===== src/ipv6_text_address_parser.sv =====
// Top level of the IPv6 text address parser: stream ports and input register.
// Depends on ipv6tap_pkg, ipv6tap_step, ipv6tap_finish and the shared assertion header.
//
// Usage:
//   Send the address text on s_axis, one ASCII character per request in
//   s_axis_tdata, and end every string with a zero byte. Only the zero byte
//   produces a request on m_axis: ok in bit 0 (1 = valid address), the upper
//   64 address bits (group 0 on top) in bits 64:1, the lower 64 bits in 128:65.
//   A rejected string reports ok = 0 with both halves zero; after an error the
//   remaining characters of that string are ignored up to the terminator.
// Throughput: one character per cycle while s_axis_tready is high, strings back to back with no gap.
//   Every character passes the input register and one step of the parser state
//   registers; the terminator then goes through the finish register and the
//   output register.
// Result path: after the input register takes the terminator, the result passes the
//   finish register and then the output register before m_axis_tvalid rises.
// Reset: arst_n clears the parser to the start of a string and empties all
//   stages; no result is pending afterwards.
// Stall: characters keep flowing while m_axis_tready is low. s_axis_tready
//   drops only when a terminator waits in the input register while the finish
//   stage and the output register both hold undelivered results.
`include "ipv6_text_address_parser_assert.svh"

module ipv6_text_address_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ipv6tap_pkg::IN_W-1:0]      s_axis_tdata,  // [7:0] ch
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ipv6tap_pkg::OUT_W-1:0]     m_axis_tdata   // [0] ok, [64:1] addr_high,
	                                                         // [128:65] addr_low, [135:129] zero
);

	logic               vld_s1;
	logic [7:0]         ch_s1;
	logic               consume;
	logic               room;
	ipv6tap_pkg::snap_t snap;

	// Plain characters always advance; a terminator needs a free finish slot.
	assign consume       = vld_s1 && (ch_s1 != ipv6tap_pkg::CH_TERM || room);
	assign s_axis_tready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	ipv6tap_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (consume),
		.ch     (ch_s1),
		.snap   (snap)
	);

	ipv6tap_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume && ch_s1 == ipv6tap_pkg::CH_TERM),
		.snap      (snap),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	`IPV6TAP_ASSERT_NEXT(a_term_waits, vld_s1 && !consume,
		vld_s1 && ch_s1 == $past(ch_s1), "held terminator dropped or changed")

endmodule

// ===== src/ipv6tap_step.sv =====
// Per-character parser state: hex groups, gap position, dotted tail and error flags.
// Depends on ipv6tap_pkg and the shared assertion header.
`include "ipv6_text_address_parser_assert.svh"

module ipv6tap_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          ch,
	output ipv6tap_pkg::snap_t  snap
);

	logic [15:0] hex_word_q, hex_word_d;
	logic [2:0]  digit_cnt_q, digit_cnt_d;
	logic [3:0]  group_cnt_q, group_cnt_d;
	logic        gap_seen_q, gap_seen_d;
	logic [2:0]  gap_idx_q, gap_idx_d;
	logic        failed_q, failed_d;
	logic        at_start_q, at_start_d;
	logic        lead_colon_q, lead_colon_d;
	logic        must_not_end_q, must_not_end_d;
	logic        must_end_q, must_end_d;
	logic        dotted_q, dotted_d;
	logic [7:0]  octet_q, octet_d;
	logic [2:0]  octet_digits_q, octet_digits_d;
	logic        dec_bad_q, dec_bad_d;
	logic [1:0]  octet_cnt_q, octet_cnt_d;
	logic [23:0] quad_q, quad_d;

	ipv6tap_pkg::group_arr_t head_q, tail_q;

	ipv6tap_pkg::hex_info_t hd;
	logic [11:0] oct_sum;
	logic        push_bad;
	logic        is_dec;
	logic        run;
	logic        colon_fail;
	logic        head_we;
	logic        tail_sh;

	assign hd      = ipv6tap_pkg::hex_decode(ch);
	assign is_dec  = (ch >= ipv6tap_pkg::CH_ZERO) && (ch <= ipv6tap_pkg::CH_NINE);
	assign oct_sum = ({4'b0, octet_q} << 3) + ({4'b0, octet_q} << 1) + {8'b0, ch[3:0]};
	assign push_bad = (octet_digits_q != 3'd0 && octet_q == 8'd0) ||
		(oct_sum > 12'(ipv6tap_pkg::OCTET_MAX));
	assign colon_fail = (digit_cnt_q == 3'd0 && gap_seen_q) || (group_cnt_q >= 4'd8);

	always_comb begin
		hex_word_d     = hex_word_q;
		digit_cnt_d    = digit_cnt_q;
		group_cnt_d    = group_cnt_q;
		gap_seen_d     = gap_seen_q;
		gap_idx_d      = gap_idx_q;
		failed_d       = failed_q;
		at_start_d     = at_start_q;
		lead_colon_d   = lead_colon_q;
		must_not_end_d = must_not_end_q;
		must_end_d     = must_end_q;
		dotted_d       = dotted_q;
		octet_d        = octet_q;
		octet_digits_d = octet_digits_q;
		dec_bad_d      = dec_bad_q;
		octet_cnt_d    = octet_cnt_q;
		quad_d         = quad_q;
		head_we        = 1'b0;
		tail_sh        = 1'b0;
		run            = 1'b0;
		if (take) begin
			if (ch == ipv6tap_pkg::CH_TERM) begin
				// Start the next string from a clean slate.
				hex_word_d     = '0;
				digit_cnt_d    = '0;
				group_cnt_d    = '0;
				gap_seen_d     = 1'b0;
				gap_idx_d      = '0;
				failed_d       = 1'b0;
				at_start_d     = 1'b1;
				lead_colon_d   = 1'b0;
				must_not_end_d = 1'b0;
				must_end_d     = 1'b0;
				dotted_d       = 1'b0;
				octet_d        = '0;
				octet_digits_d = '0;
				dec_bad_d      = 1'b0;
				octet_cnt_d    = '0;
				quad_d         = '0;
			end else if (!failed_q) begin
				run = 1'b1;
				if (at_start_q) begin
					at_start_d = 1'b0;
					if (ch == ipv6tap_pkg::CH_COLON) begin
						lead_colon_d = 1'b1;
						run          = 1'b0;
					end
				end else if (lead_colon_q) begin
					lead_colon_d = 1'b0;
					if (ch != ipv6tap_pkg::CH_COLON) begin
						failed_d = 1'b1;
						run      = 1'b0;
					end
				end
				if (run && must_end_q) begin
					failed_d = 1'b1;
					run      = 1'b0;
				end
			end
		end
		if (run) begin
			must_not_end_d = 1'b0;
			must_end_d     = 1'b0;
			if (dotted_q) begin
				if (is_dec) begin
					if (push_bad) begin
						failed_d = 1'b1;
					end else begin
						octet_d = oct_sum[7:0];
						if (octet_digits_q != 3'd7) begin
							octet_digits_d = octet_digits_q + 3'd1;
						end
					end
				end else if (ch == ipv6tap_pkg::CH_DOT) begin
					if (octet_digits_q == 3'd0 || octet_cnt_q == 2'd3) begin
						failed_d = 1'b1;
					end else begin
						quad_d         = {quad_q[15:0], octet_q};
						octet_cnt_d    = octet_cnt_q + 2'd1;
						octet_d        = '0;
						octet_digits_d = '0;
						dec_bad_d      = 1'b0;
					end
				end else begin
					failed_d = 1'b1;
				end
			end else if (hd.vld) begin
				hex_word_d  = {hex_word_q[11:0], hd.val};
				digit_cnt_d = digit_cnt_q + 3'd1;
				if (digit_cnt_q >= 3'd4) begin
					failed_d = 1'b1;
				end else if (hd.alpha) begin
					dec_bad_d = 1'b1;
				end else if (!dec_bad_q) begin
					// Track the group as a possible first IPv4 octet.
					if (push_bad) begin
						dec_bad_d = 1'b1;
					end else begin
						octet_d = oct_sum[7:0];
						if (octet_digits_q != 3'd7) begin
							octet_digits_d = octet_digits_q + 3'd1;
						end
					end
				end
			end else if (ch == ipv6tap_pkg::CH_COLON) begin
				if (colon_fail) begin
					failed_d = 1'b1;
				end else begin
					if (digit_cnt_q == 3'd0) begin
						gap_seen_d = 1'b1;
						gap_idx_d  = group_cnt_q[2:0];
						head_we    = 1'b1;
					end else begin
						must_not_end_d = 1'b1;
						head_we        = !gap_seen_q;
						tail_sh        = gap_seen_q;
					end
					group_cnt_d    = group_cnt_q + 4'd1;
					must_end_d     = (group_cnt_q == 4'd7);
					hex_word_d     = '0;
					digit_cnt_d    = '0;
					octet_d        = '0;
					octet_digits_d = '0;
					dec_bad_d      = 1'b0;
				end
			end else if (ch == ipv6tap_pkg::CH_DOT) begin
				if (group_cnt_q == 4'd0 || group_cnt_q > 4'd6 || dec_bad_q ||
						octet_digits_q == 3'd0) begin
					failed_d = 1'b1;
				end else begin
					dotted_d       = 1'b1;
					quad_d         = {16'b0, octet_q};
					octet_cnt_d    = 2'd1;
					octet_d        = '0;
					octet_digits_d = '0;
					dec_bad_d      = 1'b0;
				end
			end else begin
				failed_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_word_q     <= '0;
			digit_cnt_q    <= '0;
			group_cnt_q    <= '0;
			gap_seen_q     <= 1'b0;
			gap_idx_q      <= '0;
			failed_q       <= 1'b0;
			at_start_q     <= 1'b1;
			lead_colon_q   <= 1'b0;
			must_not_end_q <= 1'b0;
			must_end_q     <= 1'b0;
			dotted_q       <= 1'b0;
			octet_q        <= '0;
			octet_digits_q <= '0;
			dec_bad_q      <= 1'b0;
			octet_cnt_q    <= '0;
			quad_q         <= '0;
		end else begin
			hex_word_q     <= hex_word_d;
			digit_cnt_q    <= digit_cnt_d;
			group_cnt_q    <= group_cnt_d;
			gap_seen_q     <= gap_seen_d;
			gap_idx_q      <= gap_idx_d;
			failed_q       <= failed_d;
			at_start_q     <= at_start_d;
			lead_colon_q   <= lead_colon_d;
			must_not_end_q <= must_not_end_d;
			must_end_q     <= must_end_d;
			dotted_q       <= dotted_d;
			octet_q        <= octet_d;
			octet_digits_q <= octet_digits_d;
			dec_bad_q      <= dec_bad_d;
			octet_cnt_q    <= octet_cnt_d;
			quad_q         <= quad_d;
		end
	end

	// Groups up to the gap land at their own slot; groups after it shift in at the bottom.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[group_cnt_q[2:0]] <= hex_word_q;
		end
		if (tail_sh) begin
			tail_q <= {tail_q[1:7], hex_word_q};
		end
	end

	assign snap.failed       = failed_q;
	assign snap.lead_colon   = lead_colon_q;
	assign snap.must_not_end = must_not_end_q;
	assign snap.dotted       = dotted_q;
	assign snap.octet_nz     = (octet_digits_q != 3'd0);
	assign snap.octet_cnt    = octet_cnt_q;
	assign snap.octet        = octet_q;
	assign snap.quad         = quad_q;
	assign snap.digit_nz     = (digit_cnt_q != 3'd0);
	assign snap.hex_word     = hex_word_q;
	assign snap.group_cnt    = group_cnt_q;
	assign snap.gap_seen     = gap_seen_q;
	assign snap.gap_idx      = gap_idx_q;
	assign snap.head         = head_q;
	assign snap.tail         = tail_q;

	`IPV6TAP_ASSERT_SAME(a_gap_before_count, gap_seen_q && !failed_q,
		{1'b0, gap_idx_q} < group_cnt_q, "gap index not below group count")
	`IPV6TAP_ASSERT_SAME(a_digit_limit, !failed_q, digit_cnt_q <= 3'd4,
		"hex group longer than four digits without error")
	`IPV6TAP_ASSERT_NEXT(a_clear_on_term, take && ch == ipv6tap_pkg::CH_TERM,
		at_start_q && group_cnt_q == 4'd0 && !failed_q && !dotted_q,
		"state not cleared after terminator")

endmodule

// ===== src/ipv6tap_finish.sv =====
// End-of-string checks, gap fill and output register of the IPv6 text address parser.
// Depends on ipv6tap_pkg and the shared assertion header.
`include "ipv6_text_address_parser_assert.svh"

module ipv6tap_finish (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  ipv6tap_pkg::snap_t                snap,
	output logic                              room,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ipv6tap_pkg::OUT_W-1:0]     out_data
);

	logic               vld_s2;
	ipv6tap_pkg::snap_t snap_s2;
	logic               out_vld_q;
	logic [ipv6tap_pkg::OUT_W-1:0] out_data_q;

	logic                    adv;
	logic [31:0]             quad_full;
	ipv6tap_pkg::group_arr_t head_f;
	ipv6tap_pkg::group_arr_t tail_f;
	ipv6tap_pkg::group_arr_t addr;
	logic [3:0]              gc_f;
	logic [3:0]              tail_cnt;
	logic                    bad;
	logic [127:0]            addr_flat;

	assign adv  = vld_s2 && (!out_vld_q || out_ready);
	assign room = !vld_s2 || adv;

	assign quad_full = {snap_s2.quad, snap_s2.octet};

	// Place the groups that only close at the terminator.
	always_comb begin
		head_f = snap_s2.head;
		tail_f = snap_s2.tail;
		gc_f   = snap_s2.group_cnt;
		if (snap_s2.dotted) begin
			gc_f = snap_s2.group_cnt + 4'd2;
			if (snap_s2.gap_seen) begin
				tail_f = {snap_s2.tail[2:7], quad_full};
			end else begin
				for (int i = 0; i < 8; i++) begin
					if (4'(i) == snap_s2.group_cnt) begin
						head_f[i] = quad_full[31:16];
					end
					if (4'(i) == snap_s2.group_cnt + 4'd1) begin
						head_f[i] = quad_full[15:0];
					end
				end
			end
		end else if (snap_s2.digit_nz) begin
			gc_f = snap_s2.group_cnt + 4'd1;
			if (snap_s2.gap_seen) begin
				tail_f = {snap_s2.tail[1:7], snap_s2.hex_word};
			end else begin
				for (int i = 0; i < 8; i++) begin
					if (4'(i) == snap_s2.group_cnt) begin
						head_f[i] = snap_s2.hex_word;
					end
				end
			end
		end
	end

	always_comb begin
		bad = snap_s2.failed || snap_s2.lead_colon || snap_s2.must_not_end;
		if (snap_s2.dotted) begin
			if (!snap_s2.octet_nz || snap_s2.octet_cnt != 2'd3 || snap_s2.group_cnt > 4'd6) begin
				bad = 1'b1;
			end
		end else if (snap_s2.digit_nz && snap_s2.group_cnt >= 4'd8) begin
			bad = 1'b1;
		end
		if (gc_f < 4'd8 && !snap_s2.gap_seen) begin
			bad = 1'b1;
		end
	end

	assign tail_cnt = gc_f - {1'b0, snap_s2.gap_idx} - 4'd1;

	// Widen the gap: head up to it, zeros, then the tail groups bottom-aligned.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (bad) begin
				addr[i] = '0;
			end else if (!snap_s2.gap_seen || 3'(i) <= snap_s2.gap_idx) begin
				addr[i] = head_f[i];
			end else if ({1'b0, 4'(i)} + {1'b0, tail_cnt} >= 5'd8) begin
				addr[i] = tail_f[i];
			end else begin
				addr[i] = '0;
			end
		end
	end

	assign addr_flat = addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (room) begin
				vld_s2 <= load;
			end
			if (!out_vld_q || out_ready) begin
				out_vld_q <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			snap_s2 <= snap;
		end
		if (adv) begin
			out_data_q <= {7'b0, addr_flat[63:0], addr_flat[127:64], !bad};
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

	`IPV6TAP_ASSERT_SAME(a_zero_on_reject, out_vld_q && !out_data_q[0],
		out_data_q[128:1] == 128'd0, "rejected string with nonzero address")
	`IPV6TAP_ASSERT_NEXT(a_s2_hold, vld_s2 && !adv, vld_s2 && $stable(snap_s2),
		"finished string lost while output stalled")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for ipv6_text_address_parser: streams address text and checks each result.
// Depends on ipv6tap_pkg and the parser RTL; needs no files or arguments at run time.
module testbench;
	import ipv6tap_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 11;
	localparam int CHAR_TARGET  = 1700;
	localparam int DRAIN_CYCLES = 8;       // result passes the finish and output registers after the terminator
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_ROWS       = 25;

	// Codes held in the predictor's follow-up check.
	localparam logic [1:0] NEED_MORE = 2'b01;  // next character must not be the terminator
	localparam logic [1:0] NEED_END  = 2'b10;  // next character must be the terminator

	// Idling phases.
	localparam int PH_FLOW   = 0;
	localparam int PH_SENDER = 1;
	localparam int PH_STALL  = 2;
	localparam int PH_BOTH   = 3;

	// One result request as it sits on m_axis_tdata.
	typedef struct packed {
		logic [6:0]  pad;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        ok;
	} addr_result_t;

	typedef struct {
		string       text;
		bit          typed;
		bit          ok;
		logic [63:0] hi;
		logic [63:0] lo;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;

	int                   idle_pct = 0;
	int                   stall_pct = 0;
	int                   mismatches = 0;
	int                   cycle_count = 0;
	int                   chars_taken = 0;
	addr_result_t         pending_addrs [$];
	logic [7:0]           text_q [$];
	addr_result_t         got_r;
	addr_result_t         want_r;

	// Predictor state for the string being parsed.
	logic [15:0]          p_group [0:7];
	logic [15:0]          p_word;
	logic [2:0]           p_ndig;
	logic [3:0]           p_ngrp;
	logic                 p_gap;
	logic [2:0]           p_gap_at;
	logic                 p_bad;
	logic                 p_first;
	logic                 p_lead;
	logic [1:0]           p_pend;
	logic                 p_dotted;
	logic [8:0]           p_oct;
	logic [2:0]           p_onum;
	logic                 p_notdec;
	logic [1:0]           p_ocnt;
	logic [31:0]          p_quad;

	// Directed strings; the expected result is typed in where it is obvious.
	row_t rows [N_ROWS] = '{
		'{"", 1, 0, 64'h0, 64'h0},
		'{"::", 1, 1, 64'h0, 64'h0},
		'{"::1", 1, 1, 64'h0, 64'h1},
		'{"1::", 1, 1, 64'h0001_0000_0000_0000, 64'h0},
		'{"1:2:3:4:5:6:7:8", 1, 1, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008},
		'{"ffff:FFFF:ffff:FFFF:ffff:ffff:ffff:ffff", 1, 1, '1, '1},
		'{":1::", 1, 0, 64'h0, 64'h0},
		'{"1:2:3:4:5:6:7:", 1, 0, 64'h0, 64'h0},
		'{"1:2:3:4:5:6:7:8:9", 1, 0, 64'h0, 64'h0},
		'{"1:2:3:4:5:6:7:8:", 1, 0, 64'h0, 64'h0},
		'{"1::2::3", 1, 0, 64'h0, 64'h0},
		'{"12345::", 1, 0, 64'h0, 64'h0},
		'{"1:2:3", 1, 0, 64'h0, 64'h0},
		'{"::ffff:192.168.0.1", 1, 1, 64'h0, 64'h0000_ffff_c0a8_0001},
		'{"1::256.1.1.1", 1, 0, 64'h0, 64'h0},
		'{"1::01.2.3.4", 1, 0, 64'h0, 64'h0},
		'{"1::1.2.3", 1, 0, 64'h0, 64'h0},
		'{"1::1.2.3.4.5", 1, 0, 64'h0, 64'h0},
		'{"1::1..2.3", 1, 0, 64'h0, 64'h0},
		'{"1:2:3:4:5:6:7:1.2.3.4", 1, 0, 64'h0, 64'h0},
		'{"1:2:3:4:5:6:1.2.3.4", 1, 1, 64'h0001_0002_0003_0004, 64'h0005_0006_0102_0304},
		'{"g::", 1, 0, 64'h0, 64'h0},
		'{"a:b::c:d", 0, 0, 64'h0, 64'h0},
		'{"1:2:3:4:5:6:7::", 0, 0, 64'h0, 64'h0},
		'{"::255.0.0.0", 0, 0, 64'h0, 64'h0}
	};

	ipv6_text_address_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] ch
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // [0] ok, [64:1] addr_high, [128:65] addr_low
	);

	always #CLK_HALF clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stall the result side at the rate of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("mismatch %s: got %h, want %h", what, got, want);
	endtask

	// Compare every result request with the oldest expected address.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_r = m_axis_tdata;
			if (pending_addrs.size() == 0) begin
				report_mismatch("result with none expected", got_r.hi, 64'h0);
			end else begin
				want_r = pending_addrs.pop_front();
				if (got_r.ok !== want_r.ok)
					report_mismatch("ok", 64'(got_r.ok), 64'(want_r.ok));
				if (got_r.hi !== want_r.hi)
					report_mismatch("addr_high", got_r.hi, want_r.hi);
				if (got_r.lo !== want_r.lo)
					report_mismatch("addr_low", got_r.lo, want_r.lo);
				if (got_r.pad !== '0)
					report_mismatch("padding", 64'(got_r.pad), 64'h0);
			end
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void string_reset();
		p_word   = '0;
		p_ndig   = '0;
		p_ngrp   = '0;
		p_gap    = 1'b0;
		p_gap_at = '0;
		p_bad    = 1'b0;
		p_first  = 1'b1;
		p_lead   = 1'b0;
		p_pend   = '0;
		p_dotted = 1'b0;
		p_oct    = '0;
		p_onum   = '0;
		p_notdec = 1'b0;
		p_ocnt   = '0;
		p_quad   = '0;
	endfunction

	function automatic void octet_clear();
		p_oct    = '0;
		p_onum   = '0;
		p_notdec = 1'b0;
	endfunction

	// Add a decimal digit to the current octet; 0 on a leading zero or overflow.
	function automatic bit octet_add(input logic [3:0] d);
		int v;
		if (p_onum != 0 && p_oct == 0)
			return 1'b0;
		v = p_oct * 10 + d;
		if (v > OCTET_MAX)
			return 1'b0;
		p_oct = v[8:0];
		if (p_onum < 7)
			p_onum++;
		return 1'b1;
	endfunction

	function automatic bit group_put(input logic [15:0] g);
		if (p_ngrp >= 8)
			return 1'b0;
		p_group[p_ngrp[2:0]] = g;
		p_ngrp++;
		return 1'b1;
	endfunction

	function automatic void colon_take();
		if (p_ndig == 0) begin
			if (p_gap) begin
				p_bad = 1'b1;
				return;
			end
			p_gap    = 1'b1;
			p_gap_at = p_ngrp[2:0];
		end else begin
			p_pend |= NEED_MORE;
		end
		if (!group_put(p_word)) begin
			p_bad = 1'b1;
			return;
		end
		if (p_ngrp > 7)
			p_pend |= NEED_END;
		p_word = '0;
		p_ndig = '0;
		octet_clear();
	endfunction

	function automatic void char_take(input logic [7:0] c);
		logic [7:0] nib;
		bit         is_hex;
		if (p_dotted) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				nib = c - CH_ZERO;
				if (!octet_add(nib[3:0]))
					p_bad = 1'b1;
			end else if (c == CH_DOT) begin
				if (p_onum == 0 || p_ocnt >= 3) begin
					p_bad = 1'b1;
					return;
				end
				p_quad = {p_quad[23:0], p_oct[7:0]};
				p_ocnt++;
				octet_clear();
			end else begin
				p_bad = 1'b1;
			end
			return;
		end
		is_hex = 1'b1;
		if (c >= CH_ZERO && c <= CH_NINE)
			nib = c - CH_ZERO;
		else if (c >= CH_LA && c <= CH_LF)
			nib = c - CH_LA + 8'd10;
		else if (c >= CH_UA && c <= CH_UF)
			nib = c - CH_UA + 8'd10;
		else
			is_hex = 1'b0;
		if (is_hex) begin
			p_word = {p_word[11:0], nib[3:0]};
			p_ndig++;
			if (p_ndig > 4) begin
				p_bad = 1'b1;
				return;
			end
			// Track the group as a possible first IPv4 octet too.
			if (c > CH_NINE)
				p_notdec = 1'b1;
			else if (!p_notdec && !octet_add(nib[3:0]))
				p_notdec = 1'b1;
		end else if (c == CH_COLON) begin
			colon_take();
		end else if (c == CH_DOT) begin
			if (p_ngrp < 1 || p_ngrp > 6 || p_notdec || p_onum == 0) begin
				p_bad = 1'b1;
				return;
			end
			p_dotted = 1'b1;
			p_quad   = 32'(p_oct);
			p_ocnt   = 2'd1;
			octet_clear();
		end else begin
			p_bad = 1'b1;
		end
	endfunction

	// Close the string at the terminator; 1 if the text is a valid address.
	function automatic bit string_close();
		logic [31:0] q;
		if (p_bad || p_lead || (p_pend & NEED_MORE) != 0)
			return 1'b0;
		if (p_dotted) begin
			if (p_onum == 0 || p_ocnt != 3)
				return 1'b0;
			q = {p_quad[23:0], p_oct[7:0]};
			if (!group_put(q[31:16]))
				return 1'b0;
			if (!group_put(q[15:0]))
				return 1'b0;
		end else if (p_ndig != 0) begin
			if (!group_put(p_word))
				return 1'b0;
		end
		if (p_ngrp < 8 && !p_gap)
			return 1'b0;
		return 1'b1;
	endfunction

	// Advance the predictor by one character; 1 when it yields a result.
	function automatic bit parse_char(input logic [7:0] c, output addr_result_t res);
		logic [127:0] full;
		logic [15:0]  g;
		int           gap_len;
		res  = '0;
		full = '0;
		if (c == CH_TERM) begin
			if (string_close()) begin
				gap_len = 8 - p_ngrp;
				for (int i = 0; i < 8; i++) begin
					if (!p_gap || i <= p_gap_at)
						g = p_group[i];
					else if (i <= p_gap_at + gap_len)
						g = '0;
					else
						g = p_group[(i - gap_len) & 7];
					full = {full[111:0], g};
				end
				res.ok = 1'b1;
				res.hi = full[127:64];
				res.lo = full[63:0];
			end
			string_reset();
			return 1'b1;
		end
		if (p_bad)
			return 1'b0;
		if (p_first) begin
			p_first = 1'b0;
			if (c == CH_COLON) begin
				p_lead = 1'b1;
				return 1'b0;
			end
		end else if (p_lead) begin
			p_lead = 1'b0;
			if (c != CH_COLON) begin
				p_bad = 1'b1;
				return 1'b0;
			end
		end
		if ((p_pend & NEED_END) != 0) begin
			p_bad = 1'b1;
			return 1'b0;
		end
		p_pend = '0;
		char_take(c);
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void set_phase(input int ph);
		case (ph)
			PH_FLOW: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			PH_SENDER: begin
				idle_pct  = 49;
				stall_pct = 0;
			end
			PH_STALL: begin
				idle_pct  = 0;
				stall_pct = 49;
			end
			default: begin
				idle_pct  = 14;
				stall_pct = 14;
			end
		endcase
	endfunction

	// Send one character request and predict from it once it is taken.
	task automatic push_char(input logic [7:0] c, input bit typed, input addr_result_t typed_val);
		addr_result_t pred;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		chars_taken++;
		if (parse_char(c, pred))
			pending_addrs.push_back(typed ? typed_val : pred);
	endtask

	// Hold the sender until every expected address has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_addrs.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 1) == 1)
			return 8'($urandom_range(1, 255));
		case ($urandom_range(0, 5))
			0: return CH_COLON;
			1: return CH_DOT;
			2: return CH_ZERO + 8'($urandom_range(0, 9));
			3: return CH_LA + 8'($urandom_range(0, 6));
			4: return CH_UA + 8'($urandom_range(0, 6));
			default: return CH_COLON;
		endcase
	endfunction

	function automatic void add_hex_group();
		int n;
		int v;
		n = $urandom_range(1, 4);
		repeat (n) begin
			v = $urandom_range(0, 15);
			if (v < 10)
				text_q.push_back(CH_ZERO + 8'(v));
			else if ($urandom_range(0, 1) == 1)
				text_q.push_back(CH_UA + 8'(v - 10));
			else
				text_q.push_back(CH_LA + 8'(v - 10));
		end
	endfunction

	function automatic void add_octet();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = OCTET_MAX;
			default: v = $urandom_range(0, 255);
		endcase
		if (v >= 100)
			text_q.push_back(CH_ZERO + 8'(v / 100));
		if (v >= 10)
			text_q.push_back(CH_ZERO + 8'((v / 10) % 10));
		text_q.push_back(CH_ZERO + 8'(v % 10));
	endfunction

	// Build a well-formed address, with or without a gap and an IPv4 tail.
	function automatic void build_address();
		bit tail4;
		int room;
		int total;
		int head;
		int rest;
		text_q = {};
		tail4  = ($urandom_range(0, 3) == 0);
		room   = tail4 ? 6 : 8;
		if ($urandom_range(0, 2) == 0) begin
			for (int i = 0; i < room; i++) begin
				add_hex_group();
				if (tail4 || i < room - 1)
					text_q.push_back(CH_COLON);
			end
		end else begin
			total = $urandom_range(0, room - 1);
			head  = $urandom_range(0, total);
			rest  = total - head;
			for (int i = 0; i < head; i++) begin
				add_hex_group();
				if (i < head - 1)
					text_q.push_back(CH_COLON);
			end
			text_q.push_back(CH_COLON);
			text_q.push_back(CH_COLON);
			for (int i = 0; i < rest; i++) begin
				add_hex_group();
				if (tail4 || i < rest - 1)
					text_q.push_back(CH_COLON);
			end
		end
		if (tail4) begin
			for (int i = 0; i < 4; i++) begin
				add_octet();
				if (i < 3)
					text_q.push_back(CH_DOT);
			end
		end
	endfunction

	// Break a well-formed address by replacing, inserting or dropping characters.
	function automatic void damage_address();
		int pos;
		repeat ($urandom_range(1, 2)) begin
			pos = $urandom_range(0, text_q.size());
			case ($urandom_range(0, 2))
				0: if (pos < text_q.size()) text_q[pos] = pick_char();
				1: text_q.insert(pos, pick_char());
				default: if (pos < text_q.size()) text_q.delete(pos);
			endcase
		end
	endfunction

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			push_char(text_q[i], 1'b0, '0);
		push_char(CH_TERM, 1'b0, '0);
	endtask

	initial begin
		addr_result_t typed_val;
		string        line;
		int           roll;
		int           strings_sent;
		int           ph;
		int           last_ph;

		for (int i = 0; i < 8; i++)
			p_group[i] = '0;
		string_reset();
		set_phase(PH_FLOW);

		// Hold reset, then release it on a clock edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings from the table, terminator appended to each.
		for (int r = 0; r < N_ROWS; r++) begin
			line      = rows[r].text;
			typed_val = '0;
			typed_val.ok = rows[r].ok;
			typed_val.hi = rows[r].hi;
			typed_val.lo = rows[r].lo;
			for (int i = 0; i < line.len(); i++)
				push_char(line[i], 1'b0, '0);
			push_char(CH_TERM, rows[r].typed, typed_val);
		end
		drain_results();

		// Random strings: mostly well-formed, some damaged, some noise.
		strings_sent = 0;
		last_ph      = PH_FLOW;
		while (chars_taken < CHAR_TARGET) begin
			ph = (strings_sent / 8) % 4;
			if (ph != last_ph) begin
				drain_results();
				set_phase(ph);
				last_ph = ph;
			end
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				build_address();
			end else if (roll < 85) begin
				build_address();
				damage_address();
			end else begin
				text_q = {};
				repeat ($urandom_range(0, 10))
					text_q.push_back(pick_char());
			end
			send_text();
			strings_sent++;
		end

		// Wait out the last results, then idle for DRAIN_CYCLES to catch strays.
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_addrs.size() != 0)
			report_mismatch("expected results left over", 64'(pending_addrs.size()), 64'h0);

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/ipv6tap_pkg.sv
src/ipv6tap_step.sv
src/ipv6tap_finish.sv
src/ipv6_text_address_parser.sv
bench/testbench.sv
